// File: sv/egu_pkg.sv
// Package for the expectile gradient update and gain scan block.
// Holds the state machine type, register indexes and fixed-point helpers.
package egu_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_GRAD, S_SLACK, S_ACC, S_CPROD, S_DELTA, S_GF, S_T1, S_T2, S_GAIN, S_TOT,
    S_TOT2, S_OUT
  } egu_state_t;

  typedef struct packed {
    logic load;
    logic [3:0] step;
    logic clear;
  } egu_cmd_t;

  localparam logic [2:0] REG_B1 = 3'd0;
  localparam logic [2:0] REG_RB1 = 3'd1;
  localparam logic [2:0] REG_RB2 = 3'd2;
  localparam logic [2:0] REG_BGF = 3'd3;
  localparam logic [2:0] REG_GGF = 3'd4;
  localparam logic [2:0] REG_HCT = 3'd5;
  localparam logic [2:0] REG_TAU = 3'd6;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MINUS_ONE = -32'sd65536;
  localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Saturate a wide signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Add to a Q32.32 accumulator with saturation at 2^63-1.
  function automatic logic [63:0] acc_add(input logic [63:0] a, input logic [63:0] x);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, x};
    acc_add = (s > {1'b0, ACC_MAX}) ? ACC_MAX : s[63:0];
  endfunction

endpackage

// File: sv/egu_ctrl.sv
// Sequencer for the expectile gradient update block.
// Depends on egu_pkg for the state type and command struct.
module egu_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  output logic busy,
  output egu_pkg::egu_cmd_t cmd
);
  import egu_pkg::*;

  egu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_GRAD;
      S_GRAD:  state_next = S_SLACK;
      S_SLACK: state_next = S_ACC;
      S_ACC:   state_next = S_CPROD;
      S_CPROD: state_next = S_DELTA;
      S_DELTA: state_next = S_GF;
      S_GF:    state_next = S_T1;
      S_T1:    state_next = S_T2;
      S_T2:    state_next = S_GAIN;
      S_GAIN:  state_next = S_TOT;
      S_TOT:   state_next = S_TOT2;
      S_TOT2:  state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = in_fire;
    cmd.step = state;
    cmd.clear = (state == S_OUT) && out_free;
    busy = (state != S_IDLE);
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE)
    else $error("item accepted while busy");
  assert property (@(posedge clk) disable iff (rst) state == S_GAIN |=> state == S_TOT)
    else $error("sequence skipped total");
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_OUT && !out_free) |=> state == S_OUT)
    else $error("result dropped");
endmodule

// File: sv/egu_datapath.sv
// Datapath: gain formula stages stepped by the sequencer, and the pass state.
// Depends on egu_pkg for helpers and the command struct.
module egu_datapath #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic clk,
  input  logic rst,
  input  egu_pkg::egu_cmd_t cmd,
  input  logic [272:0] in_data,
  input  logic signed [31:0] reg_b1,
  input  logic signed [31:0] recip_b1,
  input  logic signed [31:0] recip_b2,
  input  logic signed [31:0] beta_gain_factor,
  input  logic signed [31:0] gamma_gain_factor,
  input  logic signed [31:0] half_over_c_tau,
  input  logic [16:0] expectile_tau,
  output logic [175:0] out_data,
  output logic out_last
);
  import egu_pkg::*;

  logic signed [31:0] k1, k2, gbi, ggi, beta, gamma, s1, s2;
  logic [15:0] idx;
  logic last;
  logic signed [31:0] gb, gg, slack, c, delta, eta, gf1, gf2, t, gain;
  logic signed [47:0] pa, pb;
  logic [63:0] sp2, sn2;
  logic signed [31:0] peak_gain;
  logic [15:0] peak_index;
  logic [63:0] pos_acc, neg_acc, tot_a, tot_b, tot_sum;
  logic [16:0] tau;
  logic [15:0] idx_cap;

  function automatic logic signed [47:0] qmul(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    qmul = p[63:16];
  endfunction

  function automatic logic [63:0] scale(input logic [63:0] a, input logic [16:0] w);
    logic [80:0] hi;
    logic [32:0] lo;
    hi = {17'd0, a[63:16]} * {64'd0, w};
    lo = {17'd0, a[15:0]} * {16'd0, w};
    scale = hi[63:0] + {47'd0, lo[32:16]};
  endfunction

  assign tau = (expectile_tau > 17'd65536) ? 17'd65536 : expectile_tau;
  assign idx_cap = ({16'd0, idx} >= 32'(MAX_SAMPLES)) ? 16'(MAX_SAMPLES - 1) : idx;
  assign tot_sum = acc_add(tot_a, tot_b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {last, s2, s1, idx, gamma, beta, ggi, gbi, k2, k1} <= in_data;
    end
    case (cmd.step)
      S_IDLE: ;
      S_GRAD: begin
        gb <= sat32(66'(gbi) - 66'(sat32(66'(qmul(s2, k2)) + 66'(qmul(s1, k1)))));
        gg <= sat32(66'(ggi) + 66'(sat32(66'(qmul(s2, k2)) + 66'(qmul(s1, k1)))));
      end
      S_SLACK: begin
        slack <= sat32(66'(qmul(beta, half_over_c_tau)) + 66'(gb));
        pa <= qmul(reg_b1, beta);
      end
      S_ACC: begin
        sp2 <= (slack > 0) ? 64'(66'(slack) * 66'(slack)) : 64'd0;
        sn2 <= (slack < 0) ? 64'(66'(slack) * 66'(slack)) : 64'd0;
        c <= sat32(66'(gb) + 66'(pa) - 66'(gamma));
      end
      S_CPROD: begin
        pa <= qmul(recip_b1, (c > 0) ? c : 32'sd0);
        pb <= qmul(-33'(recip_b2), (c < 0) ? c : 32'sd0);
      end
      S_DELTA: begin
        delta <= sat32(66'(pa) - 66'(beta));
        eta <= sat32(66'(pb) - 66'(gamma));
      end
      S_GF: begin
        gf1 <= sat32(66'(gb) + 66'(qmul(-33'(beta_gain_factor), delta)));
        gf2 <= sat32(66'(gg) + 66'(qmul(-33'(gamma_gain_factor), eta)));
      end
      S_T1: t <= sat32(66'(qmul(eta, gf2)));
      S_T2: t <= sat32(66'(qmul(delta, eta)) + 66'(t));
      S_GAIN: gain <= sat32(66'(qmul(delta, gf1)) + 66'(t));
      S_TOT: begin
        tot_a <= scale(pos_acc, tau);
        tot_b <= scale(neg_acc, 17'd65536 - tau);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.clear && last)) begin
      peak_gain <= Q_MINUS_ONE;
      peak_index <= '0;
      pos_acc <= '0;
      neg_acc <= '0;
    end else begin
      if (cmd.step == S_CPROD) begin
        pos_acc <= acc_add(pos_acc, sp2);
        neg_acc <= acc_add(neg_acc, sn2);
      end
      if (cmd.step == S_TOT && gain > peak_gain) begin
        peak_gain <= gain;
        peak_index <= idx_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == S_TOT2) begin
      out_last <= last;
      out_data <= {1'b0, last ? tot_sum[62:0] : 63'd0,
                   last ? peak_gain : 32'sd0, last ? peak_index : 16'd0, gg, gb};
    end
  end

  assert property (@(posedge clk) disable iff (rst) pos_acc <= ACC_MAX)
    else $error("positive accumulator overflow");
  assert property (@(posedge clk) disable iff (rst) neg_acc <= ACC_MAX)
    else $error("negative accumulator overflow");
  assert property (@(posedge clk) disable iff (rst)
                   $past(cmd.clear && last) |-> peak_gain == Q_MINUS_ONE)
    else $error("pass state not cleared");
endmodule

// File: sv/expectile_gradient_update_gain_scan.sv
// Top level of the expectile gradient update and gain scan block.
// Instantiates egu_ctrl and egu_datapath; uses egu_pkg.
//
// Usage: one sample per input beat on the s_axis channel; one result beat per
// sample on m_axis. The beat with tlast set closes the pass: its result carries
// the best index, best gain and slack total, and the pass state then clears.
// One item at a time: a new input beat is taken only while the sequencer is idle,
// after the eleven datapath stages and the result beat; an output stall holds it
// longer. The sequencer steps the gain formula one stage per cycle.
// Configuration must be written over the APB port while idle (the block does not enforce it); registers at 4*i.
// Reset (rst, synchronous) restores the register defaults and clears the pass.
// When the receiver stalls, the result holds and no new input is accepted.
// Registers read back over prdata.
//
// Field layout is in the port comments.
module expectile_gradient_update_gain_scan #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // k1, k2, grad_beta_in, grad_gamma_in, beta_weight, gamma_weight,
  // sample_index, step_first, step_second
  input  logic [271:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // grad_beta_out, grad_gamma_out, best_sample, best_gain_out, slack_total, pad
  output logic [175:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import egu_pkg::*;

  logic signed [31:0] reg_b1, recip_b1, recip_b2, beta_gain_factor;
  logic signed [31:0] gamma_gain_factor, half_over_c_tau;
  logic [16:0] expectile_tau;
  logic busy, in_fire, out_free;
  logic [175:0] dp_out;
  logic dp_last;
  egu_cmd_t cmd;

  assign pready = 1'b1;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign out_free = m_axis_tready;
  assign m_axis_tvalid = (cmd.step == S_OUT);
  assign m_axis_tlast = dp_last;
  assign m_axis_tdata = dp_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_b1 <= Q_ONE;
      recip_b1 <= Q_ONE;
      recip_b2 <= Q_ONE;
      beta_gain_factor <= '0;
      gamma_gain_factor <= '0;
      half_over_c_tau <= '0;
      expectile_tau <= 17'd32768;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_B1:  reg_b1 <= pwdata;
        REG_RB1: recip_b1 <= pwdata;
        REG_RB2: recip_b2 <= pwdata;
        REG_BGF: beta_gain_factor <= pwdata;
        REG_GGF: gamma_gain_factor <= pwdata;
        REG_HCT: half_over_c_tau <= pwdata;
        REG_TAU: expectile_tau <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_B1:  prdata = reg_b1;
      REG_RB1: prdata = recip_b1;
      REG_RB2: prdata = recip_b2;
      REG_BGF: prdata = beta_gain_factor;
      REG_GGF: prdata = gamma_gain_factor;
      REG_HCT: prdata = half_over_c_tau;
      REG_TAU: prdata = {15'd0, expectile_tau};
      default: prdata = '0;
    endcase
  end

  egu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .busy(busy), .cmd(cmd)
  );

  egu_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_data({s_axis_tlast, s_axis_tdata}),
    .reg_b1(reg_b1), .recip_b1(recip_b1), .recip_b2(recip_b2),
    .beta_gain_factor(beta_gain_factor), .gamma_gain_factor(gamma_gain_factor),
    .half_over_c_tau(half_over_c_tau), .expectile_tau(expectile_tau),
    .out_data(dp_out), .out_last(dp_last)
  );
endmodule
